/* rtl/core/fpc_pkg.sv */
package fpc_pkg;

  localparam int CORDIC_STEPS = 18;
  localparam int STEP_W = 5;
  localparam int VEC_W = 33;
  localparam int LANE_W = 36;
  localparam int ANG_W = 21;
  localparam int DIFF_W = ANG_W + 1;
  localparam int FOV_W = 19;
  localparam int IDX_W = 8;
  localparam int LANES = 4;

  localparam int LANE_HP = 0;
  localparam int LANE_VP = 1;
  localparam int LANE_HD = 2;
  localparam int LANE_VD = 3;

  localparam logic signed [ANG_W-1:0] ANG_PI = ANG_W'(205887);

  typedef enum logic [IDX_W-1:0] {
    REG_ORIGIN_X = IDX_W'(0),
    REG_ORIGIN_Y = IDX_W'(1),
    REG_ORIGIN_Z = IDX_W'(2),
    REG_DIR_X    = IDX_W'(3),
    REG_DIR_Y    = IDX_W'(4),
    REG_DIR_Z    = IDX_W'(5),
    REG_HFOV     = IDX_W'(6),
    REG_VFOV     = IDX_W'(7)
  } reg_idx_t;

  typedef struct packed {
    logic signed [LANE_W-1:0] a;
    logic signed [LANE_W-1:0] b;
    logic signed [ANG_W-1:0]  ang;
    logic                     zero;
  } lane_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } point_t;

  typedef struct packed {
    lane_t [LANES-1:0] lane;
    point_t            pt;
  } cell_t;

  function automatic logic signed [ANG_W-1:0] atan_q16(logic [STEP_W-1:0] step);
    logic signed [ANG_W-1:0] r;
    unique case (step)
      STEP_W'(0):  r = ANG_W'(51472);
      STEP_W'(1):  r = ANG_W'(30386);
      STEP_W'(2):  r = ANG_W'(16055);
      STEP_W'(3):  r = ANG_W'(8150);
      STEP_W'(4):  r = ANG_W'(4091);
      STEP_W'(5):  r = ANG_W'(2047);
      STEP_W'(6):  r = ANG_W'(1024);
      STEP_W'(7):  r = ANG_W'(512);
      STEP_W'(8):  r = ANG_W'(256);
      STEP_W'(9):  r = ANG_W'(128);
      STEP_W'(10): r = ANG_W'(64);
      STEP_W'(11): r = ANG_W'(32);
      STEP_W'(12): r = ANG_W'(16);
      STEP_W'(13): r = ANG_W'(8);
      STEP_W'(14): r = ANG_W'(4);
      STEP_W'(15): r = ANG_W'(2);
      STEP_W'(16): r = ANG_W'(1);
      default:     r = '0;
    endcase
    return r;
  endfunction

  function automatic lane_t lane_start(logic signed [VEC_W-1:0] a, logic signed [VEC_W-1:0] b);
    lane_t l;
    logic signed [LANE_W-1:0] ae;
    logic signed [LANE_W-1:0] be;
    ae = {{(LANE_W-VEC_W){a[VEC_W-1]}}, a};
    be = {{(LANE_W-VEC_W){b[VEC_W-1]}}, b};
    l.zero = (a == '0) && (b == '0);
    if (b[VEC_W-1]) begin
      l.ang = a[VEC_W-1] ? -ANG_PI : ANG_PI;
      l.a = -ae;
      l.b = -be;
    end else begin
      l.ang = '0;
      l.a = ae;
      l.b = be;
    end
    return l;
  endfunction

  function automatic lane_t lane_iter(lane_t l, logic [STEP_W-1:0] step);
    lane_t r;
    logic signed [LANE_W-1:0] da;
    logic signed [LANE_W-1:0] db;
    da = l.a >>> step;
    db = l.b >>> step;
    r.zero = l.zero;
    if (!l.a[LANE_W-1]) begin
      r.b = l.b + da;
      r.a = l.a - db;
      r.ang = l.ang + atan_q16(step);
    end else begin
      r.b = l.b - da;
      r.a = l.a + db;
      r.ang = l.ang - atan_q16(step);
    end
    return r;
  endfunction

endpackage

/* rtl/core/fpc_point_if.sv */
interface fpc_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic               cloud_end;
  modport source(output valid, point_x, point_y, point_z, cloud_end, input ready);
  modport sink(input valid, point_x, point_y, point_z, cloud_end, output ready);
endinterface

/* rtl/core/fpc_result_if.sv */
interface fpc_result_if;
  logic               valid;
  logic               ready;
  logic               visible;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               out_last;
  modport source(output valid, visible, out_x, out_y, out_z, out_last, input ready);
  modport sink(input valid, visible, out_x, out_y, out_z, out_last, output ready);
endinterface

/* rtl/core/fpc_cfg_if.sv */
interface fpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/core/fov_point_cull_core.sv */
// Channel | Dir | Payload                                  | Transfer
// pt      | in  | point_x, point_y, point_z, cloud_end     | valid & ready
// res     | out | visible, out_x, out_y, out_z, out_last   | valid & ready
// cfg     | in  | index, data                              | valid & ready
// One point is accepted per cycle unless a stall on the result channel has backed up to the input.
// The row of CORDIC cells performs one iteration per cell.
// Every stage holds its item while the next is full, so gaps close up under a stall.
// Synchronous reset clears all valid bits and restores the register defaults.
module fov_point_cull_core (
  input logic         clk,
  input logic         rst,
  fpc_point_if.sink   pt,
  fpc_result_if.source res,
  fpc_cfg_if.sink     cfg
);
  import fpc_pkg::*;

  logic signed [31:0]      origin_x, origin_y, origin_z;
  logic signed [31:0]      dir_x, dir_y, dir_z;
  logic [FOV_W-1:0]        hfov, vfov;

  logic                    s0_v, s0_rdy;
  logic signed [VEC_W-1:0] vx, vy, vz;
  point_t                  s0_pt;

  logic                    s1_v, s1_rdy;
  cell_t                   s1_d;

  logic                    c_v   [CORDIC_STEPS+1];
  logic                    c_rdy [CORDIC_STEPS+1];
  cell_t                   c_d   [CORDIC_STEPS+1];

  logic                    j1_v, j1_rdy, j2_rdy;
  logic signed [DIFF_W-1:0] dh, dv;
  point_t                  j1_pt;
  logic signed [ANG_W-1:0] a_hp, a_vp, a_hd, a_vd;
  logic [DIFF_W-1:0]       mag_h, mag_v;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      origin_z <= '0;
      dir_x    <= 32'sd65536;
      dir_y    <= '0;
      dir_z    <= '0;
      hfov     <= '0;
      vfov     <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ORIGIN_X: origin_x <= cfg.data;
        REG_ORIGIN_Y: origin_y <= cfg.data;
        REG_ORIGIN_Z: origin_z <= cfg.data;
        REG_DIR_X:    dir_x    <= cfg.data;
        REG_DIR_Y:    dir_y    <= cfg.data;
        REG_DIR_Z:    dir_z    <= cfg.data;
        REG_HFOV:     hfov     <= cfg.data[FOV_W-1:0];
        REG_VFOV:     vfov     <= cfg.data[FOV_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 0: vector from origin to point.
  assign s0_rdy = !s0_v || s1_rdy;
  assign pt.ready = s0_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (s0_rdy) begin
      s0_v <= pt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_rdy && pt.valid) begin
      vx <= VEC_W'(pt.point_x) - VEC_W'(origin_x);
      vy <= VEC_W'(pt.point_y) - VEC_W'(origin_y);
      vz <= VEC_W'(pt.point_z) - VEC_W'(origin_z);
      s0_pt <= '{x: pt.point_x, y: pt.point_y, z: pt.point_z, last: pt.cloud_end};
    end
  end

  // Stage 1: pre-rotation into the right half plane.
  assign s1_rdy = !s1_v || c_rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s1_rdy) begin
      s1_v <= s0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && s0_v) begin
      s1_d.pt <= s0_pt;
      s1_d.lane[LANE_HP] <= lane_start(vy, vx);
      s1_d.lane[LANE_VP] <= lane_start(vy, vz);
      s1_d.lane[LANE_HD] <= lane_start(VEC_W'(dir_y), VEC_W'(dir_x));
      s1_d.lane[LANE_VD] <= lane_start(VEC_W'(dir_y), VEC_W'(dir_z));
    end
  end

  assign c_v[0] = s1_v;
  assign c_d[0] = s1_d;
  assign c_rdy[CORDIC_STEPS] = j1_rdy;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    fpc_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .step      (STEP_W'(i)),
      .in_valid  (c_v[i]),
      .in_ready  (c_rdy[i]),
      .in_data   (c_d[i]),
      .out_valid (c_v[i+1]),
      .out_ready (c_rdy[i+1]),
      .out_data  (c_d[i+1])
    );
  end

  // Angle differences.
  always_comb begin
    a_hp = c_d[CORDIC_STEPS].lane[LANE_HP].zero ? '0 : c_d[CORDIC_STEPS].lane[LANE_HP].ang;
    a_vp = c_d[CORDIC_STEPS].lane[LANE_VP].zero ? '0 : c_d[CORDIC_STEPS].lane[LANE_VP].ang;
    a_hd = c_d[CORDIC_STEPS].lane[LANE_HD].zero ? '0 : c_d[CORDIC_STEPS].lane[LANE_HD].ang;
    a_vd = c_d[CORDIC_STEPS].lane[LANE_VD].zero ? '0 : c_d[CORDIC_STEPS].lane[LANE_VD].ang;
  end

  assign j1_rdy = !j1_v || j2_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      j1_v <= 1'b0;
    end else if (j1_rdy) begin
      j1_v <= c_v[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (j1_rdy && c_v[CORDIC_STEPS]) begin
      dh <= DIFF_W'(a_hp) - DIFF_W'(a_hd);
      dv <= DIFF_W'(a_vp) - DIFF_W'(a_vd);
      j1_pt <= c_d[CORDIC_STEPS].pt;
    end
  end

  // Output register: window test.
  assign mag_h = dh[DIFF_W-1] ? DIFF_W'(-dh) : DIFF_W'(dh);
  assign mag_v = dv[DIFF_W-1] ? DIFF_W'(-dv) : DIFF_W'(dv);
  assign j2_rdy = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (j2_rdy) begin
      res.valid <= j1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (j2_rdy && j1_v) begin
      res.visible  <= ({mag_h, 1'b0} <= (DIFF_W+1)'(hfov)) &&
                      ({mag_v, 1'b0} <= (DIFF_W+1)'(vfov));
      res.out_x    <= j1_pt.x;
      res.out_y    <= j1_pt.y;
      res.out_z    <= j1_pt.z;
      res.out_last <= j1_pt.last;
    end
  end

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !pt.ready |-> (res.valid && !res.ready && j1_v && s0_v && s1_v))
    else $error("input stalled while the pipeline has room");

  a_prerot_right: assert property (@(posedge clk) disable iff (rst)
    s1_v |-> (!s1_d.lane[LANE_HP].b[LANE_W-1] && !s1_d.lane[LANE_VP].b[LANE_W-1]))
    else $error("pre-rotation left a vector in the left half plane");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(j1_v))
    else $error("result appeared without an item in the difference stage");

endmodule

/* rtl/core/fpc_cordic_cell.sv */
module fpc_cordic_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [fpc_pkg::STEP_W-1:0] step,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  fpc_pkg::cell_t            in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output fpc_pkg::cell_t            out_data
);
  import fpc_pkg::*;

  cell_t data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    data_next.pt = in_data.pt;
    for (int k = 0; k < LANES; k++) begin
      data_next.lane[k] = lane_iter(in_data.lane[k], step);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

/* test/fov_point_cull_core_test.sv */
module fov_point_cull_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fpc_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED_LO = IDX_W'(8);
  localparam logic [IDX_W-1:0] REG_UNUSED_HI = IDX_W'(255);
  localparam int FOV_MAX = 411775;
  localparam int PIPE_WAIT = CORDIC_STEPS + 20;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } point_item_t;

  typedef struct {
    logic               visible;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } cull_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fpc_point_if  pt_ch();
  fpc_result_if res_ch();
  fpc_cfg_if    cfg_ch();

  fov_point_cull_core i_dut (
    .clk(clk),
    .rst(rst),
    .pt(pt_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  always #2 clk = ~clk;

  logic signed [31:0] org_x, org_y, org_z;
  logic signed [31:0] view_x, view_y, view_z;
  logic [FOV_W-1:0]   fov_h, fov_v;

  point_item_t  points_pending[$];
  cull_result_t results_expected[$];
  int           errors = 0;
  int           hold_left = 0;
  bit           pt_taken = 1'b0;
  int           burst_left = 0;
  int           gap_left = 0;
  int           stall_mode = 0;
  int           stall_timer = 0;

  function automatic longint cordic_angle(longint a, longint b);
    longint ang;
    longint da;
    longint db;
    longint step_atan[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                              256, 128, 64, 32, 16, 8, 4, 2, 1};
    ang = 0;
    if (a == 0 && b == 0) return 0;
    if (b < 0) begin
      ang = (a >= 0) ? 205887 : -205887;
      a = -a;
      b = -b;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      da = a >>> i;
      db = b >>> i;
      if (a >= 0) begin
        b = b + da;
        a = a - db;
        if (i < 17) ang += step_atan[i];
      end else begin
        b = b - da;
        a = a + db;
        if (i < 17) ang -= step_atan[i];
      end
    end
    return ang;
  endfunction

  // Returns twice the absolute horizontal and vertical angle offsets.
  function automatic void angle_offsets(point_item_t p, output longint h2, output longint v2);
    longint vx, vy, vz, dh, dv;
    vx = longint'(p.x) - longint'(org_x);
    vy = longint'(p.y) - longint'(org_y);
    vz = longint'(p.z) - longint'(org_z);
    dh = cordic_angle(vy, vx) - cordic_angle(longint'(view_y), longint'(view_x));
    dv = cordic_angle(vy, vz) - cordic_angle(longint'(view_y), longint'(view_z));
    h2 = 2 * (dh < 0 ? -dh : dh);
    v2 = 2 * (dv < 0 ? -dv : dv);
  endfunction

  function automatic cull_result_t predict_cull(point_item_t p);
    cull_result_t r;
    longint h2, v2;
    angle_offsets(p, h2, v2);
    r.visible = (h2 <= longint'(fov_h)) && (v2 <= longint'(fov_v));
    r.x = p.x;
    r.y = p.y;
    r.z = p.z;
    r.last = p.last;
    return r;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      pt_ch.valid <= 1'b0;
    end else if (!(pt_ch.valid && !pt_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        pt_ch.valid <= 1'b0;
      end else if (points_pending.size() > 0) begin
        pt_ch.valid <= 1'b1;
        pt_ch.point_x <= points_pending[0].x;
        pt_ch.point_y <= points_pending[0].y;
        pt_ch.point_z <= points_pending[0].z;
        pt_ch.cloud_end <= points_pending[0].last;
        void'(points_pending.pop_front());
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(0, 12);
          gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 9);
        end
      end else begin
        pt_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      if (stall_timer == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_timer = $urandom_range(10, 80);
      end else begin
        stall_timer--;
      end
      case (stall_mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= 1'($urandom_range(0, 1));
        2: res_ch.ready <= $urandom_range(0, 3) == 0;
        default: res_ch.ready <= $urandom_range(0, 7) != 0;
      endcase
    end
  end

  always @(posedge clk) begin
    point_item_t  p;
    cull_result_t want;
    pt_taken = pt_ch.valid && pt_ch.ready && !rst;
    if (pt_taken) begin
      p.x = pt_ch.point_x;
      p.y = pt_ch.point_y;
      p.z = pt_ch.point_z;
      p.last = pt_ch.cloud_end;
      results_expected.push_back(predict_cull(p));
    end
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (results_expected.size() == 0) begin
        $display("unexpected result transfer at %0t", $realtime);
        errors++;
      end else begin
        want = results_expected.pop_front();
        if (res_ch.visible !== want.visible) report("visible", res_ch.visible, want.visible);
        if (res_ch.out_x !== want.x) report("out_x", res_ch.out_x, want.x);
        if (res_ch.out_y !== want.y) report("out_y", res_ch.out_y, want.y);
        if (res_ch.out_z !== want.z) report("out_z", res_ch.out_z, want.z);
        if (res_ch.out_last !== want.last) report("out_last", res_ch.out_last, want.last);
      end
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_ORIGIN_X: org_x = value;
      REG_ORIGIN_Y: org_y = value;
      REG_ORIGIN_Z: org_z = value;
      REG_DIR_X:    view_x = value;
      REG_DIR_Y:    view_y = value;
      REG_DIR_Z:    view_z = value;
      REG_HFOV:     fov_h = value[FOV_W-1:0];
      REG_VFOV:     fov_v = value[FOV_W-1:0];
      default: ;
    endcase
  endtask

  task automatic release_cfg();
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (points_pending.size() > 0 || pt_ch.valid || results_expected.size() > 0);
    repeat (PIPE_WAIT) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_coord(logic signed [31:0] base,
                                                    logic signed [31:0] dir);
    logic signed [31:0] edges[5] = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 1};
    case ($urandom_range(0, 9))
      0, 1, 2: return base + $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      3, 4:    return $urandom;
      5:       return edges[$urandom_range(0, 4)];
      6:       return base;
      7, 8:    return base + (dir >>> $urandom_range(0, 8));
      default: return base + $signed($urandom_range(0, 15)) - 8;
    endcase
  endfunction

  function automatic point_item_t random_point();
    point_item_t p;
    p.x = pick_coord(org_x, view_x);
    p.y = pick_coord(org_y, view_y);
    p.z = pick_coord(org_z, view_z);
    p.last = $urandom_range(0, 7) == 0;
    return p;
  endfunction

  function automatic point_item_t make_point(int x, int y, int z, bit last);
    point_item_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.last = last;
    return p;
  endfunction

  function automatic logic [31:0] random_word();
    logic [31:0] edges[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    if ($urandom_range(0, 4) == 0) return edges[$urandom_range(0, 3)];
    if ($urandom_range(0, 1) == 0) return $urandom;
    return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
  endfunction

  initial begin
    point_item_t p;
    longint h2, v2;
    pt_ch.valid = 1'b0;
    pt_ch.point_x = '0;
    pt_ch.point_y = '0;
    pt_ch.point_z = '0;
    pt_ch.cloud_end = 1'b0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    org_x = 0; org_y = 0; org_z = 0;
    view_x = 65536; view_y = 0; view_z = 0;
    fov_h = 0; fov_v = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    points_pending.push_back(make_point(0, 0, 0, 1'b0));
    points_pending.push_back(make_point(65536, 0, 0, 1'b1));
    points_pending.push_back(make_point(-65536, 0, 0, 1'b0));
    points_pending.push_back(make_point(-65536, 5, -7, 1'b0));
    points_pending.push_back(make_point(-65536, -5, -7, 1'b1));
    points_pending.push_back(make_point(65536, -5, 0, 1'b0));
    points_pending.push_back(make_point(0, 65536, 0, 1'b0));
    points_pending.push_back(make_point(0, -65536, 0, 1'b0));
    points_pending.push_back(make_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1));
    points_pending.push_back(make_point(32'h80000000, 32'h80000000, 32'h80000000, 1'b0));
    points_pending.push_back(make_point(32'h7fffffff, 32'h80000000, 0, 1'b1));
    points_pending.push_back(make_point(32'h80000000, 32'h7fffffff, -1, 1'b0));
    points_pending.push_back(make_point(-1, -1, -1, 1'b1));
    points_pending.push_back(make_point(1, 0, 1, 1'b0));
    for (int i = 0; i < 6; i++) points_pending.push_back(random_point());
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        write_reg(REG_ORIGIN_X, 32'h8000_0000);
        write_reg(REG_ORIGIN_Y, 32'h7fff_ffff);
        write_reg(REG_ORIGIN_Z, 32'h8000_0000);
        write_reg(REG_DIR_X, 32'h7fff_ffff);
        write_reg(REG_DIR_Y, 32'h8000_0000);
        write_reg(REG_DIR_Z, 32'h0);
        write_reg(REG_HFOV, FOV_MAX);
        write_reg(REG_VFOV, FOV_MAX);
      end else if (phase == 1) begin
        write_reg(REG_ORIGIN_X, 0);
        write_reg(REG_ORIGIN_Y, 0);
        write_reg(REG_ORIGIN_Z, 0);
        write_reg(REG_DIR_X, 0);
        write_reg(REG_DIR_Y, 0);
        write_reg(REG_DIR_Z, 0);
        write_reg(REG_HFOV, 0);
        write_reg(REG_VFOV, FOV_MAX);
      end else begin
        write_reg(REG_ORIGIN_X, random_word());
        write_reg(REG_ORIGIN_Y, random_word());
        write_reg(REG_ORIGIN_Z, random_word());
        write_reg(REG_DIR_X, random_word());
        write_reg(REG_DIR_Y, random_word());
        write_reg(REG_DIR_Z, random_word());
        write_reg(REG_HFOV, $urandom_range(0, FOV_MAX));
        write_reg(REG_VFOV, $urandom_range(0, FOV_MAX));
      end
      write_reg(phase[0] ? REG_UNUSED_LO : REG_UNUSED_HI, $urandom);
      if (phase == 3 || phase == 6) begin
        // Place a point exactly on both field of view limits, unless an offset exceeds FOV_MAX.
        p = random_point();
        angle_offsets(p, h2, v2);
        write_reg(REG_HFOV, 32'(h2 > FOV_MAX ? longint'(FOV_MAX) : h2));
        write_reg(REG_VFOV, 32'(v2 > FOV_MAX ? longint'(FOV_MAX) : v2));
        points_pending.push_back(p);
        p.x = p.x + 1;
        points_pending.push_back(p);
      end
      release_cfg();
      for (int i = 0; i < 240; i++) points_pending.push_back(random_point());
      if (phase == 4) hold_left = LONG_HOLD;
      drain();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule

/* files.f */
rtl/core/fpc_pkg.sv
rtl/core/fpc_point_if.sv
rtl/core/fpc_result_if.sv
rtl/core/fpc_cfg_if.sv
rtl/core/fpc_cordic_cell.sv
rtl/core/fov_point_cull_core.sv
test/fov_point_cull_core_test.sv
